// ----- hw/rtl/lifn_pkg.sv -----
package lifn_pkg;

  // Default sizes of the neuron table and of the fixed-point format.
  localparam int NEURONS_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int NEURON_W  = 12;
  localparam int DATA_W    = 32;
  localparam int DECAY_W   = 17;
  localparam int REFR_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Width in which products and sums are saturated back to DATA_W.
  localparam int WIDE_W = 66;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_V_DECAY          = 3'd0,
    CFG_I_DECAY          = 3'd1,
    CFG_SYN_GAIN         = 3'd2,
    CFG_BIAS_GAIN        = 3'd3,
    CFG_V_THRESHOLD      = 3'd4,
    CFG_V_RESET          = 3'd5,
    CFG_REST_POTENTIAL   = 3'd6,
    CFG_REFRACTORY_STEPS = 3'd7
  } cfg_idx_t;

  // Item operation codes.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  // Configuration register file contents.
  typedef struct packed {
    logic        [DECAY_W-1:0] v_decay;
    logic        [DECAY_W-1:0] i_decay;
    logic signed [DATA_W-1:0]  syn_gain;
    logic signed [DATA_W-1:0]  bias_gain;
    logic signed [DATA_W-1:0]  v_threshold;
    logic signed [DATA_W-1:0]  v_reset;
    logic signed [DATA_W-1:0]  rest_potential;
    logic        [REFR_W-1:0]  refractory_steps;
  } cfg_t;

  // One entry of the neuron state memory.
  typedef struct packed {
    logic signed [DATA_W-1:0] potential;
    logic signed [DATA_W-1:0] current;
    logic        [REFR_W-1:0] refr;
    logic signed [DATA_W-1:0] bias;
  } nstate_t;

  // Saturate a wide signed value to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (!v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '0)) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '1)) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/lifn_if.sv -----
// Input item channel.
interface lifn_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic        [lifn_pkg::NEURON_W-1:0]  neuron;
  logic signed [lifn_pkg::DATA_W-1:0]    weight;
  logic signed [lifn_pkg::DATA_W-1:0]    bias;
  logic signed [lifn_pkg::DATA_W-1:0]    init_potential;

  modport source (output valid, op, neuron, weight, bias, init_potential, input ready);
  modport sink   (input valid, op, neuron, weight, bias, init_potential, output ready);
endinterface

// Result item channel.
interface lifn_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [lifn_pkg::NEURON_W-1:0]  neuron_out;
  logic                                  spiked;
  logic signed [lifn_pkg::DATA_W-1:0]    potential;
  logic        [lifn_pkg::REFR_W-1:0]    refractory_left;

  modport source (output valid, neuron_out, spiked, potential, refractory_left, input ready);
  modport sink   (input valid, neuron_out, spiked, potential, refractory_left, output ready);
endinterface

// ----- hw/rtl/lifn_cfg.sv -----
module lifn_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lifn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lifn_pkg::DATA_W-1:0]      cfg_wdata,
  output lifn_pkg::cfg_t                   cfg_o
);

  lifn_pkg::cfg_t cfg_r;
  lifn_pkg::cfg_t cfg_nxt;

  // Decode a write into the addressed register; other fields keep their value.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lifn_pkg::cfg_idx_t'(cfg_index))
        lifn_pkg::CFG_V_DECAY:          cfg_nxt.v_decay = cfg_wdata[lifn_pkg::DECAY_W-1:0];
        lifn_pkg::CFG_I_DECAY:          cfg_nxt.i_decay = cfg_wdata[lifn_pkg::DECAY_W-1:0];
        lifn_pkg::CFG_SYN_GAIN:         cfg_nxt.syn_gain = cfg_wdata;
        lifn_pkg::CFG_BIAS_GAIN:        cfg_nxt.bias_gain = cfg_wdata;
        lifn_pkg::CFG_V_THRESHOLD:      cfg_nxt.v_threshold = cfg_wdata;
        lifn_pkg::CFG_V_RESET:          cfg_nxt.v_reset = cfg_wdata;
        lifn_pkg::CFG_REST_POTENTIAL:   cfg_nxt.rest_potential = cfg_wdata;
        lifn_pkg::CFG_REFRACTORY_STEPS: cfg_nxt.refractory_steps =
                                          cfg_wdata[lifn_pkg::REFR_W-1:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register file with its reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.v_decay          <= lifn_pkg::DECAY_W'(65536);
      cfg_r.i_decay          <= lifn_pkg::DECAY_W'(65536);
      cfg_r.syn_gain         <= lifn_pkg::DATA_W'(65536);
      cfg_r.bias_gain        <= lifn_pkg::DATA_W'(65536);
      cfg_r.v_threshold      <= lifn_pkg::DATA_W'(983040);
      cfg_r.v_reset          <= '0;
      cfg_r.rest_potential   <= '0;
      cfg_r.refractory_steps <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- hw/rtl/lifn_mem.sv -----
module lifn_mem #(
  parameter int NEURONS = lifn_pkg::NEURONS_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(NEURONS)-1:0]   rd_addr,
  output lifn_pkg::nstate_t            rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(NEURONS)-1:0]   wr_addr,
  input  lifn_pkg::nstate_t            wr_data
);

  lifn_pkg::nstate_t ram_r [NEURONS];
  lifn_pkg::nstate_t rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ram_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/lif_neuron_update.sv -----
// An accepted item passes stages 0 to 5 and then the output register, which holds its result item.
// Throughput: one item per cycle while results are taken at once and no item repeats a neuron
// of the five items before it. An item whose neuron is still in flight waits in the entry stage
// until the earlier item writes the state memory back; a stall on the result side delays that
// write-back too (read-modify-write loop).
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults; the state memory is not cleared, so a neuron is loaded before its updates.
module lif_neuron_update #(
  parameter int NEURONS   = lifn_pkg::NEURONS_DEF,
  parameter int FRAC_BITS = lifn_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lifn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lifn_pkg::DATA_W-1:0]     cfg_wdata,
  lifn_in_if.sink                         in_ch,
  lifn_out_if.source                      out_ch
);

  localparam int NW     = lifn_pkg::NEURON_W;
  localparam int DW     = lifn_pkg::DATA_W;
  localparam int RW     = lifn_pkg::REFR_W;
  localparam int WW     = lifn_pkg::WIDE_W;
  localparam int DECW   = lifn_pkg::DECAY_W;
  localparam int AW     = $clog2(NEURONS);
  localparam int MOD_W  = NW + AW;
  localparam int PW     = 3 * NW;
  // Reciprocal for the index reduction, exact for every NW-bit index.
  localparam int RECIP  = ((1 << (2 * NW)) + NEURONS - 1) / NEURONS;

  lifn_pkg::cfg_t    cfg;
  lifn_pkg::nstate_t rd_data;
  lifn_pkg::nstate_t wr_data;

  lifn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Stage valid bits and flow control.
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_v_r;
  logic s0_go, s1_go, s2_go, s3_go, s4_go, s5_go;
  logic s1_free, s2_free, s3_free, s4_free, s5_free, out_free;
  logic hazard;
  logic in_acc;

  // Stage 0: accepted item and index quotient.
  lifn_pkg::op_t         s0_op_r;
  logic [NW-1:0]         s0_neuron_r;
  logic signed [DW-1:0]  s0_weight_r;
  logic signed [DW-1:0]  s0_bias_r;
  logic signed [DW-1:0]  s0_init_r;
  logic [NW-1:0]         s0_q_r;
  logic [PW-1:0]         qprod;
  logic [MOD_W-1:0]      rem0;
  logic [AW-1:0]         addr0;

  // Stage 1: memory data arrives.
  lifn_pkg::op_t         s1_op_r;
  logic [NW-1:0]         s1_neuron_r;
  logic [AW-1:0]         s1_addr_r;
  logic signed [DW-1:0]  s1_weight_r;
  logic signed [DW-1:0]  s1_bias_r;
  logic signed [DW-1:0]  s1_init_r;
  logic signed [DECW:0]  vdec_s;
  logic signed [DECW:0]  idec_s;

  // Stage 2: decay and bias products.
  lifn_pkg::op_t         s2_op_r;
  logic [NW-1:0]         s2_neuron_r;
  logic [AW-1:0]         s2_addr_r;
  logic signed [DW-1:0]  s2_weight_r;
  logic signed [DW-1:0]  s2_bias_r;
  logic [RW-1:0]         s2_refr_r;
  logic signed [DW-1:0]  s2_ldpot_r;
  logic signed [DW+DECW:0] s2_prod_c_r, prod_c_nxt;
  logic signed [DW+DECW:0] s2_prod_p_r, prod_p_nxt;
  logic signed [2*DW-1:0]  s2_prod_b_r, prod_b_nxt;
  logic signed [DW-1:0]  bias_wb_nxt;
  logic signed [DW-1:0]  ldpot_nxt;

  // Stage 3: new current and scaled terms.
  lifn_pkg::op_t         s3_op_r;
  logic [NW-1:0]         s3_neuron_r;
  logic [AW-1:0]         s3_addr_r;
  logic signed [DW-1:0]  s3_bias_r;
  logic [RW-1:0]         s3_refr_r;
  logic signed [DW-1:0]  s3_ldpot_r;
  logic signed [DW-1:0]  s3_cur_r, cur_nxt;
  logic signed [DW-1:0]  s3_pv_r, pv_nxt;
  logic signed [DW-1:0]  s3_pb_r, pb_nxt;
  logic signed [DW-1:0]  pc;

  // Stage 4: synaptic gain product.
  lifn_pkg::op_t         s4_op_r;
  logic [NW-1:0]         s4_neuron_r;
  logic [AW-1:0]         s4_addr_r;
  logic signed [DW-1:0]  s4_bias_r;
  logic [RW-1:0]         s4_refr_r;
  logic signed [DW-1:0]  s4_ldpot_r;
  logic signed [DW-1:0]  s4_cur_r;
  logic signed [DW-1:0]  s4_pv_r;
  logic signed [DW-1:0]  s4_pb_r;
  logic signed [2*DW-1:0] s4_prod_s_r, prod_s_nxt;

  // Stage 5: integrated potential.
  lifn_pkg::op_t         s5_op_r;
  logic [NW-1:0]         s5_neuron_r;
  logic [AW-1:0]         s5_addr_r;
  logic signed [DW-1:0]  s5_bias_r;
  logic [RW-1:0]         s5_refr_r;
  logic signed [DW-1:0]  s5_ldpot_r;
  logic signed [DW-1:0]  s5_cur_r;
  logic signed [DW-1:0]  s5_vn_r, vn_nxt;
  logic signed [DW-1:0]  ps;

  // Output register.
  logic [NW-1:0]         out_neuron_r;
  logic                  out_spiked_r, spk_nxt;
  logic signed [DW-1:0]  out_pot_r, pot_nxt;
  logic [RW-1:0]         out_refr_r, refr_nxt;
  logic signed [DW-1:0]  cur_wb;

  // Each stage moves on when the stage after it is empty or moving on; stage 0 also waits out a hazard.
  assign out_free = !out_v_r || out_ch.ready;
  assign s5_go    = s5_v_r && out_free;
  assign s5_free  = !s5_v_r || s5_go;
  assign s4_go    = s4_v_r && s5_free;
  assign s4_free  = !s4_v_r || s4_go;
  assign s3_go    = s3_v_r && s4_free;
  assign s3_free  = !s3_v_r || s3_go;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_go;
  assign s0_go    = s0_v_r && !hazard && s1_free;

  assign in_ch.ready = !s0_v_r || s0_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Index reduction: quotient by reciprocal at entry, remainder in stage 0.
  assign qprod = PW'(in_ch.neuron) * PW'(RECIP);
  assign rem0  = MOD_W'(s0_neuron_r) - MOD_W'(s0_q_r) * MOD_W'(NEURONS);
  assign addr0 = rem0[AW-1:0];

  // An item may not read a neuron that an earlier item has yet to write back.
  assign hazard = (s1_v_r && (s1_addr_r == addr0)) ||
                  (s2_v_r && (s2_addr_r == addr0)) ||
                  (s3_v_r && (s3_addr_r == addr0)) ||
                  (s4_v_r && (s4_addr_r == addr0)) ||
                  (s5_v_r && (s5_addr_r == addr0));

  lifn_mem #(
    .NEURONS (NEURONS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (s0_go),
    .rd_addr (addr0),
    .rd_data (rd_data),
    .wr_en   (s5_go),
    .wr_addr (s5_addr_r),
    .wr_data (wr_data)
  );

  // Stage 1 math: the three products that need only stored state, the bias to write back and the load potential.
  assign vdec_s      = {1'b0, cfg.v_decay};
  assign idec_s      = {1'b0, cfg.i_decay};
  assign prod_c_nxt  = rd_data.current * idec_s;
  assign prod_p_nxt  = rd_data.potential * vdec_s;
  assign prod_b_nxt  = rd_data.bias * cfg.bias_gain;
  assign bias_wb_nxt = (s1_op_r == lifn_pkg::OP_LOAD) ? s1_bias_r : rd_data.bias;
  assign ldpot_nxt   = lifn_pkg::sat32(WW'(s1_init_r) - WW'(cfg.rest_potential));

  // Stage 2 math: scale products back and form the new current.
  assign pc      = lifn_pkg::sat32(WW'(s2_prod_c_r >>> FRAC_BITS));
  assign cur_nxt = lifn_pkg::sat32(WW'(pc) + WW'(s2_weight_r));
  assign pv_nxt  = lifn_pkg::sat32(WW'(s2_prod_p_r >>> FRAC_BITS));
  assign pb_nxt  = lifn_pkg::sat32(WW'(s2_prod_b_r >>> FRAC_BITS));

  // Stage 3 math: current to potential gain.
  assign prod_s_nxt = s3_cur_r * cfg.syn_gain;

  // Stage 4 math: sum of the three potential terms.
  assign ps     = lifn_pkg::sat32(WW'(s4_prod_s_r >>> FRAC_BITS));
  assign vn_nxt = lifn_pkg::sat32(WW'(s4_pv_r) + WW'(ps) + WW'(s4_pb_r));

  // Stage 5: load, refractory hold, or threshold test.
  always_comb begin
    spk_nxt  = 1'b0;
    pot_nxt  = s5_vn_r;
    refr_nxt = '0;
    cur_wb   = s5_cur_r;
    if (s5_op_r == lifn_pkg::OP_LOAD) begin
      pot_nxt = s5_ldpot_r;
      cur_wb  = '0;
    end else if (s5_refr_r != '0) begin
      pot_nxt  = cfg.v_reset;
      refr_nxt = s5_refr_r - RW'(1);
    end else if (s5_vn_r >= cfg.v_threshold) begin
      spk_nxt  = 1'b1;
      pot_nxt  = cfg.v_reset;
      refr_nxt = cfg.refractory_steps;
    end
  end

  assign wr_data.potential = pot_nxt;
  assign wr_data.current   = cur_wb;
  assign wr_data.refr      = refr_nxt;
  assign wr_data.bias      = s5_bias_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) s0_v_r  <= in_ch.valid;
      if (s1_free)     s1_v_r  <= s0_go;
      if (s2_free)     s2_v_r  <= s1_go;
      if (s3_free)     s3_v_r  <= s2_go;
      if (s4_free)     s4_v_r  <= s3_go;
      if (s5_free)     s5_v_r  <= s4_go;
      if (out_free)    out_v_r <= s5_go;
    end
  end

  // Payload registers, loaded as an item moves into each stage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_op_r     <= lifn_pkg::op_t'(in_ch.op);
      s0_neuron_r <= in_ch.neuron;
      s0_weight_r <= in_ch.weight;
      s0_bias_r   <= in_ch.bias;
      s0_init_r   <= in_ch.init_potential;
      s0_q_r      <= qprod[PW-1 -: NW];
    end
    if (s0_go) begin
      s1_op_r     <= s0_op_r;
      s1_neuron_r <= s0_neuron_r;
      s1_addr_r   <= addr0;
      s1_weight_r <= s0_weight_r;
      s1_bias_r   <= s0_bias_r;
      s1_init_r   <= s0_init_r;
    end
    if (s1_go) begin
      s2_op_r     <= s1_op_r;
      s2_neuron_r <= s1_neuron_r;
      s2_addr_r   <= s1_addr_r;
      s2_weight_r <= s1_weight_r;
      s2_bias_r   <= bias_wb_nxt;
      s2_refr_r   <= rd_data.refr;
      s2_ldpot_r  <= ldpot_nxt;
      s2_prod_c_r <= prod_c_nxt;
      s2_prod_p_r <= prod_p_nxt;
      s2_prod_b_r <= prod_b_nxt;
    end
    if (s2_go) begin
      s3_op_r     <= s2_op_r;
      s3_neuron_r <= s2_neuron_r;
      s3_addr_r   <= s2_addr_r;
      s3_bias_r   <= s2_bias_r;
      s3_refr_r   <= s2_refr_r;
      s3_ldpot_r  <= s2_ldpot_r;
      s3_cur_r    <= cur_nxt;
      s3_pv_r     <= pv_nxt;
      s3_pb_r     <= pb_nxt;
    end
    if (s3_go) begin
      s4_op_r     <= s3_op_r;
      s4_neuron_r <= s3_neuron_r;
      s4_addr_r   <= s3_addr_r;
      s4_bias_r   <= s3_bias_r;
      s4_refr_r   <= s3_refr_r;
      s4_ldpot_r  <= s3_ldpot_r;
      s4_cur_r    <= s3_cur_r;
      s4_pv_r     <= s3_pv_r;
      s4_pb_r     <= s3_pb_r;
      s4_prod_s_r <= prod_s_nxt;
    end
    if (s4_go) begin
      s5_op_r     <= s4_op_r;
      s5_neuron_r <= s4_neuron_r;
      s5_addr_r   <= s4_addr_r;
      s5_bias_r   <= s4_bias_r;
      s5_refr_r   <= s4_refr_r;
      s5_ldpot_r  <= s4_ldpot_r;
      s5_cur_r    <= s4_cur_r;
      s5_vn_r     <= vn_nxt;
    end
    if (s5_go) begin
      out_neuron_r <= s5_neuron_r;
      out_spiked_r <= spk_nxt;
      out_pot_r    <= pot_nxt;
      out_refr_r   <= refr_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.neuron_out      = out_neuron_r;
  assign out_ch.spiked          = out_spiked_r;
  assign out_ch.potential       = out_pot_r;
  assign out_ch.refractory_left = out_refr_r;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int FRAC = lifn_pkg::FRAC_BITS_DEF;
  localparam int TABLE_SIZE = lifn_pkg::NEURONS_DEF;
  localparam logic signed [lifn_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [lifn_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam int ONE = 1 << FRAC;

  // One input item as the driver presents it.
  typedef struct {
    lifn_pkg::op_t                      op;
    logic [lifn_pkg::NEURON_W-1:0]      neuron;
    logic signed [lifn_pkg::DATA_W-1:0] weight;
    logic signed [lifn_pkg::DATA_W-1:0] bias;
    logic signed [lifn_pkg::DATA_W-1:0] init_potential;
  } neuron_item_t;

  // One predicted result item.
  typedef struct {
    logic [lifn_pkg::NEURON_W-1:0]      neuron;
    logic                               spiked;
    logic signed [lifn_pkg::DATA_W-1:0] potential;
    logic [lifn_pkg::REFR_W-1:0]        refr;
  } neuron_result_t;

  // Scoreboard: mirrors the neuron table and the registers, and predicts the
  // result of every accepted item.
  class neuron_scoreboard;
    lifn_pkg::cfg_t                     regs;
    logic signed [lifn_pkg::DATA_W-1:0] pot_mem[TABLE_SIZE];
    logic signed [lifn_pkg::DATA_W-1:0] cur_mem[TABLE_SIZE];
    logic signed [lifn_pkg::DATA_W-1:0] bias_mem[TABLE_SIZE];
    logic [lifn_pkg::REFR_W-1:0]        refr_mem[TABLE_SIZE];
    neuron_result_t                     predicted_results[$];
    int                                 errors;

    function new();
      regs.v_decay          = 17'(ONE);
      regs.i_decay          = 17'(ONE);
      regs.syn_gain         = ONE;
      regs.bias_gain        = ONE;
      regs.v_threshold      = 15 * ONE;
      regs.v_reset          = 0;
      regs.rest_potential   = 0;
      regs.refractory_steps = 0;
      errors = 0;
    endfunction

    function logic signed [lifn_pkg::DATA_W-1:0] clamp32(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[lifn_pkg::DATA_W-1:0];
    endfunction

    // Exact product, floor shift by the fraction width, then saturate.
    function logic signed [lifn_pkg::DATA_W-1:0] fx_mul(longint a, longint b);
      longint p;
      p = (a * b) >>> FRAC;
      return clamp32(p);
    endfunction

    // Advance the mirrored table by one item and queue the expected result.
    function void predict_step(neuron_item_t it);
      int                                 n;
      logic                               spk;
      logic signed [lifn_pkg::DATA_W-1:0] pot;
      logic signed [lifn_pkg::DATA_W-1:0] cur;
      logic signed [lifn_pkg::DATA_W-1:0] vn;
      logic [lifn_pkg::REFR_W-1:0]        refr;
      longint                             sum;
      n = int'(it.neuron) % TABLE_SIZE;
      spk = 1'b0;
      if (it.op == lifn_pkg::OP_LOAD) begin
        pot = clamp32(longint'(it.init_potential) - longint'($signed(regs.rest_potential)));
        refr = '0;
        pot_mem[n] = pot;
        bias_mem[n] = it.bias;
        cur_mem[n] = '0;
        refr_mem[n] = '0;
      end else begin
        cur = clamp32(longint'(fx_mul(cur_mem[n], longint'(regs.i_decay))) +
                      longint'(it.weight));
        cur_mem[n] = cur;
        if (refr_mem[n] != '0) begin
          // Refractory neurons are pinned at reset and never fire.
          refr = refr_mem[n] - 1'b1;
          pot = regs.v_reset;
        end else begin
          sum = longint'(fx_mul(pot_mem[n], longint'(regs.v_decay))) +
                longint'(fx_mul(cur, longint'($signed(regs.syn_gain)))) +
                longint'(fx_mul(bias_mem[n], longint'($signed(regs.bias_gain))));
          vn = clamp32(sum);
          if (vn >= $signed(regs.v_threshold)) begin
            spk = 1'b1;
            pot = regs.v_reset;
            refr = regs.refractory_steps;
          end else begin
            pot = vn;
            refr = '0;
          end
        end
        pot_mem[n] = pot;
        refr_mem[n] = refr;
      end
      predicted_results.push_back('{it.neuron, spk, pot, refr});
    endfunction

    function void compare_field(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Match one result item against the oldest prediction.
    function void check_result(logic [lifn_pkg::NEURON_W-1:0] neuron, logic spiked,
                               logic signed [lifn_pkg::DATA_W-1:0] potential,
                               logic [lifn_pkg::REFR_W-1:0] refr);
      neuron_result_t want;
      if (predicted_results.size() == 0) begin
        $error("result item for neuron %0d arrived with nothing predicted", neuron);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      compare_field("neuron_out", want.neuron, neuron);
      compare_field("spiked", want.spiked, spiked);
      compare_field("potential", want.potential, potential);
      compare_field("refractory_left", want.refr, refr);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lifn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lifn_pkg::DATA_W-1:0] cfg_wdata;
  int cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit loaded[TABLE_SIZE];
  int loaded_list[$];

  neuron_scoreboard sb = new();

  lifn_in_if  in_ch();
  lifn_out_if out_ch();

  lif_neuron_update DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.neuron_out, out_ch.spiked, out_ch.potential,
                      out_ch.refractory_left);
    end
  end

  // Result side: random stalls before each item, or none during a burst.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Symmetric random value of up to the given number of whole units.
  function automatic logic signed [lifn_pkg::DATA_W-1:0] rand_q(int units);
    int span;
    span = units * ONE;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly moderate values, now and then the extremes or any bit pattern.
  function automatic logic signed [lifn_pkg::DATA_W-1:0] rand_field(int units);
    case ($urandom_range(0, 31))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom;
      default: return rand_q(units);
    endcase
  endfunction

  function automatic lifn_pkg::cfg_t random_settings();
    lifn_pkg::cfg_t c;
    c.v_decay          = 17'($urandom_range(ONE / 2, ONE));
    c.i_decay          = 17'($urandom_range(0, ONE));
    c.syn_gain         = $urandom_range(0, 2 * ONE);
    if ($urandom_range(0, 7) == 0) c.syn_gain = -c.syn_gain;
    c.bias_gain        = $urandom_range(0, ONE);
    c.v_threshold      = $urandom_range(ONE, 20 * ONE);
    c.v_reset          = rand_q(3);
    c.rest_potential   = rand_q(64);
    c.refractory_steps = 16'($urandom_range(0, 4));
    return c;
  endfunction

  // Register word for a write; unused upper bits carry noise.
  function automatic logic [lifn_pkg::DATA_W-1:0] reg_word(lifn_pkg::cfg_t c,
                                                           lifn_pkg::cfg_idx_t idx);
    case (idx)
      lifn_pkg::CFG_V_DECAY:          return {15'($urandom), c.v_decay};
      lifn_pkg::CFG_I_DECAY:          return {15'($urandom), c.i_decay};
      lifn_pkg::CFG_SYN_GAIN:         return c.syn_gain;
      lifn_pkg::CFG_BIAS_GAIN:        return c.bias_gain;
      lifn_pkg::CFG_V_THRESHOLD:      return c.v_threshold;
      lifn_pkg::CFG_V_RESET:          return c.v_reset;
      lifn_pkg::CFG_REST_POTENTIAL:   return c.rest_potential;
      lifn_pkg::CFG_REFRACTORY_STEPS: return {16'($urandom), c.refractory_steps};
      default:                        return '0;
    endcase
  endfunction

  // Offer one item after a random gap and wait until it is taken.
  task automatic offer_item(neuron_item_t it);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.neuron         <= it.neuron;
    in_ch.weight         <= it.weight;
    in_ch.bias           <= it.bias;
    in_ch.init_potential <= it.init_potential;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_step(it);
  endtask

  task automatic load_neuron(int n, logic signed [lifn_pkg::DATA_W-1:0] init,
                             logic signed [lifn_pkg::DATA_W-1:0] bias);
    if (!loaded[n]) begin
      loaded[n] = 1'b1;
      loaded_list.push_back(n);
    end
    offer_item('{lifn_pkg::OP_LOAD, lifn_pkg::NEURON_W'(n), $urandom, bias, init});
  endtask

  task automatic update_neuron(int n, logic signed [lifn_pkg::DATA_W-1:0] weight);
    offer_item('{lifn_pkg::OP_UPDATE, lifn_pkg::NEURON_W'(n), weight, $urandom, $urandom});
  endtask

  task automatic load_random(int n);
    logic signed [lifn_pkg::DATA_W-1:0] init;
    init = ($urandom_range(0, 7) == 0) ? rand_field(8) :
           sb.regs.rest_potential + rand_q(8);
    load_neuron(n, init, rand_field(2));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
  endtask

  // Write all registers while the block is idle.
  task automatic apply_settings(lifn_pkg::cfg_t c);
    lifn_pkg::cfg_idx_t idx;
    drain();
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= reg_word(c, idx);
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    sb.regs = c;
  endtask

  // A working set of neurons is loaded and then stepped through repeated
  // timesteps; reloads and strays into other loaded neurons add noise.
  task automatic run_phase(int n_items);
    int set_q[$];
    int count;
    int n;
    repeat ($urandom_range(1, 12)) begin
      n = $urandom_range(0, TABLE_SIZE - 1);
      if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 1) ? TABLE_SIZE - 1 : 0;
      load_random(n);
      set_q.push_back(n);
    end
    count = set_q.size();
    while (count < n_items) begin
      foreach (set_q[k]) begin
        if ($urandom_range(0, 15) == 0) load_random(set_q[k]);
        else update_neuron(set_q[k], rand_field(4));
        count++;
        if ($urandom_range(0, 19) == 0) begin
          update_neuron(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                        rand_field(4));
          count++;
        end
        if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      end
    end
  endtask

  initial begin
    lifn_pkg::cfg_t c;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= lifn_pkg::OP_LOAD;
    in_ch.neuron         <= '0;
    in_ch.weight         <= '0;
    in_ch.bias           <= '0;
    in_ch.init_potential <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= lifn_pkg::CFG_V_DECAY;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: saturating sums, threshold met exactly and just missed.
    load_neuron(0, 0, 0);
    load_neuron(TABLE_SIZE - 1, Q_MAX, Q_MAX);
    update_neuron(TABLE_SIZE - 1, Q_MAX);
    update_neuron(TABLE_SIZE - 1, Q_MIN);
    load_neuron(1, Q_MIN, Q_MIN);
    update_neuron(1, Q_MIN);
    update_neuron(0, 15 * ONE);
    load_neuron(2, 0, 0);
    update_neuron(2, 15 * ONE - 1);

    // Half decays, a two step refractory period and a rest level at the top,
    // so a load can saturate and negative products round down.
    c.v_decay          = 17'(ONE / 2);
    c.i_decay          = 17'(ONE / 2);
    c.syn_gain         = ONE;
    c.bias_gain        = ONE / 2;
    c.v_threshold      = ONE;
    c.v_reset          = -5 * ONE;
    c.rest_potential   = Q_MAX;
    c.refractory_steps = 16'd2;
    apply_settings(c);
    load_neuron(3, Q_MIN, 0);
    load_neuron(5, Q_MAX, -1);
    update_neuron(5, 2 * ONE);
    update_neuron(5, -3);
    update_neuron(5, -3);
    update_neuron(5, -3);
    update_neuron(3, -1);
    update_neuron(3, 0);

    // Register extremes, one way and then the other.
    c.v_decay          = 17'(ONE);
    c.i_decay          = 17'(ONE);
    c.syn_gain         = Q_MAX;
    c.bias_gain        = Q_MIN;
    c.v_threshold      = Q_MAX;
    c.v_reset          = Q_MIN;
    c.rest_potential   = Q_MIN;
    c.refractory_steps = 16'hffff;
    apply_settings(c);
    run_phase(100);

    c.v_decay          = '0;
    c.i_decay          = '0;
    c.syn_gain         = Q_MIN;
    c.bias_gain        = 0;
    c.v_threshold      = Q_MIN;
    c.v_reset          = Q_MAX;
    c.rest_potential   = Q_MAX;
    c.refractory_steps = '0;
    apply_settings(c);
    run_phase(100);

    // Random working settings.
    repeat (5) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      apply_settings(random_settings());
      run_phase(220);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
